/* hdl/spwlo_pkg.sv */
// ----------------------------------------------------------------------------
// spwlo_pkg: shared types and constants for the slot pool
// Opcodes, status codes, bitmap row geometry and the in-row free-slot encoder.
// ----------------------------------------------------------------------------
package spwlo_pkg;

    // bitmap row geometry
    localparam int ROW_W  = 64;
    localparam int ROW_BW = 6;

    // stream word widths
    localparam int IN_W  = 8;
    localparam int OUT_W = 24;

    // operation codes
    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_RELEASE = 2'd1,
        OP_NEXT    = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_NOT_USED = 2'd2,
        ST_NO_NEXT  = 2'd3
    } status_t;

    // bitmap row write command
    typedef struct packed {
        logic             en;
        logic [ROW_W-1:0] data;
    } bm_wr_t;

    // lowest clear bit of a bitmap row
    function automatic logic [ROW_BW-1:0] first_zero(input logic [ROW_W-1:0] v);
        logic [ROW_BW-1:0] r;
        r = '0;
        for (int i = ROW_W - 1; i >= 0; i--) begin
            if (!v[i]) begin
                r = ROW_BW'(i);
            end
        end
        return r;
    endfunction

endpackage

/* hdl/spwlo_bitmap.sv */
// ----------------------------------------------------------------------------
// spwlo_bitmap: used-slot bitmap
// Rows of 64 used bits in a synchronous memory, a valid bit per row so that
// unwritten rows read as all free, and a row-full summary with a priority
// encoder that points at the first row holding a free slot.
// ----------------------------------------------------------------------------
module spwlo_bitmap
    import spwlo_pkg::*;
#(
    parameter int NROWS = 1,
    parameter int LAST_BITS = 64,
    parameter int RIW = 1
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             rd_en,
    input  logic [RIW-1:0]   rd_row,
    output logic [ROW_W-1:0] rd_data,
    input  bm_wr_t           wr,
    input  logic [RIW-1:0]   wr_row,
    output logic [RIW-1:0]   free_row
);

    // bits past the end of the pool in the last row always count as used
    localparam logic [ROW_W-1:0] LAST_MASK = (LAST_BITS >= ROW_W) ? '0 :
        ~((ROW_W'(1) << LAST_BITS) - ROW_W'(1));

    logic [ROW_W-1:0] row_mem [NROWS];
    logic [NROWS-1:0] row_valid_reg;
    logic [NROWS-1:0] row_full_reg;
    logic [ROW_W-1:0] rd_data_reg;
    logic             rd_ok_reg;
    logic             rd_last_reg;

    // row storage
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            row_mem[wr_row] <= wr.data;
        end
        if (rd_en) begin
            rd_data_reg <= row_mem[rd_row];
            rd_ok_reg   <= row_valid_reg[rd_row];
            rd_last_reg <= (rd_row == RIW'(NROWS - 1));
        end
    end

    // per-row written and full flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_valid_reg <= '0;
            row_full_reg  <= '0;
        end else if (wr.en) begin
            row_valid_reg[wr_row] <= 1'b1;
            row_full_reg[wr_row]  <= &wr.data;
        end
    end

    // read data, unwritten rows are free
    assign rd_data = (rd_ok_reg ? rd_data_reg : '0) | (rd_last_reg ? LAST_MASK : '0);

    // first row that is not full
    always_comb begin
        free_row = '0;
        for (int r = NROWS - 1; r >= 0; r--) begin
            if (!row_full_reg[r]) begin
                free_row = RIW'(r);
            end
        end
    end

endmodule

/* hdl/spwlo_links.sv */
// ----------------------------------------------------------------------------
// spwlo_links: forward and backward link memories
// Two synchronous memories, one read and one write port each, holding the
// circular doubly linked allocation order.
// ----------------------------------------------------------------------------
module spwlo_links
    import spwlo_pkg::*;
#(
    parameter int SLOT_COUNT = 64,
    parameter int IW = 6
) (
    input  logic          aclk,
    input  logic          rd_en,
    input  logic [IW-1:0] fwd_rd_addr,
    input  logic [IW-1:0] bwd_rd_addr,
    output logic [IW-1:0] fwd_rd_data,
    output logic [IW-1:0] bwd_rd_data,
    input  logic          fwd_we,
    input  logic [IW-1:0] fwd_wr_addr,
    input  logic [IW-1:0] fwd_wr_data,
    input  logic          bwd_we,
    input  logic [IW-1:0] bwd_wr_addr,
    input  logic [IW-1:0] bwd_wr_data
);

    logic [IW-1:0] fwd_mem [SLOT_COUNT];
    logic [IW-1:0] bwd_mem [SLOT_COUNT];

    // forward links
    always_ff @(posedge aclk) begin
        if (fwd_we) begin
            fwd_mem[fwd_wr_addr] <= fwd_wr_data;
        end
        if (rd_en) begin
            fwd_rd_data <= fwd_mem[fwd_rd_addr];
        end
    end

    // backward links
    always_ff @(posedge aclk) begin
        if (bwd_we) begin
            bwd_mem[bwd_wr_addr] <= bwd_wr_data;
        end
        if (rd_en) begin
            bwd_rd_data <= bwd_mem[bwd_rd_addr];
        end
    end

endmodule

/* hdl/slot_pool_with_linked_order.sv */
// ----------------------------------------------------------------------------
// slot_pool_with_linked_order: slot allocator with allocation-order list
// Hands out the lowest free slot, keeps used slots in a circular doubly
// linked list in allocation order, releases slots and walks the order.
//
// Usage:
//   s_ channel: one command word per transfer (opcode, slot index).
//   m_ channel: one result word per command (status, slot, in-use flag,
//   live count, head slot, head valid).
//   A command is taken when the block is idle and its result register is
//   empty or being drained. The bitmap row and the links are read as the
//   command is accepted; the result is formed in the execute state and
//   registered there. A new command is taken only after the last is done;
//   an allocate into a non-empty list adds a link state that writes the old
//   tail's forward link and the head's backward link through the single
//   write port of each link memory.
//   The lowest free slot comes from a priority encoder over the row-full
//   summary followed by one over the 64-bit bitmap row read from memory.
//   Reset: all slots free, list empty, count zero; per-row valid flags make
//   the bitmap read as free without a clearing pass, so no dead time.
//   A stalled m_tready holds the result word and blocks new commands.
// ----------------------------------------------------------------------------
module slot_pool_with_linked_order
    import spwlo_pkg::*;
#(
    parameter int SLOT_COUNT = 64
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // opcode[1:0], slot_index[7:2]
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata    // status[1:0], result_slot[7:2],
                                        // slot_in_use[8], live_count[15:9],
                                        // head_slot[21:16], head_valid[22],
                                        // zero[23]
);

    localparam int IW        = $clog2(SLOT_COUNT);
    localparam int CW        = $clog2(SLOT_COUNT + 1);
    localparam int XW        = (IW > ROW_BW) ? IW : ROW_BW;
    localparam int NROWS     = (SLOT_COUNT + ROW_W - 1) / ROW_W;
    localparam int RIW       = (NROWS > 1) ? $clog2(NROWS) : 1;
    localparam int LAST_BITS = SLOT_COUNT - (NROWS - 1) * ROW_W;

    typedef enum logic [2:0] {
        FSM_IDLE = 3'b001,
        FSM_EXEC = 3'b010,
        FSM_LINK = 3'b100
    } fsm_t;

    fsm_t              state_reg, state_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [IW-1:0]     head_reg, head_next;
    logic              hv_reg, hv_next;
    logic [IW-1:0]     a_reg, a_next;
    logic [IW-1:0]     tail_reg, tail_next;
    op_t               op_reg;
    logic              range_reg;
    logic [IW-1:0]     sidx_reg;
    logic [RIW-1:0]    row_reg;
    logic [ROW_BW-1:0] bit_reg;
    logic              m_tvalid_reg;
    logic [OUT_W-1:0]  m_tdata_reg, m_tdata_next;

    // input word decode
    op_t               in_op;
    logic [XW-1:0]     in_x;
    logic              in_range;
    logic [IW-1:0]     in_sidx;
    logic [RIW-1:0]    in_row;
    logic [RIW-1:0]    rd_row;
    logic              acc;

    // memory side
    logic [ROW_W-1:0]  bm_rd;
    bm_wr_t            bm_wr;
    logic [RIW-1:0]    free_row;
    logic [IW-1:0]     fwd_q, bwd_q;
    logic              f_we, b_we;
    logic [IW-1:0]     f_wa, f_wd, b_wa, b_wd;

    // execute helpers
    logic [ROW_BW-1:0] alloc_bit;
    logic [XW-1:0]     alloc_x;
    logic [IW-1:0]     alloc_slot;
    logic              was_used;
    logic              out_load;
    status_t           status;
    logic [IW-1:0]     rslot;
    logic              inuse;

    assign in_op    = op_t'(s_tdata[1:0]);
    assign in_x     = XW'(s_tdata[7:2]);
    assign in_range = {1'b0, in_x} < (XW + 1)'(SLOT_COUNT);
    assign in_sidx  = in_x[IW-1:0];
    assign in_row   = RIW'(in_x >> ROW_BW);
    assign rd_row   = (in_op == OP_ALLOC) ? free_row : in_row;

    assign s_tready = (state_reg == FSM_IDLE) && (!m_tvalid_reg || m_tready);
    assign acc      = s_tvalid && s_tready;

    // used bitmap
    spwlo_bitmap #(
        .NROWS     (NROWS),
        .LAST_BITS (LAST_BITS),
        .RIW       (RIW)
    ) u_bitmap (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (acc),
        .rd_row   (rd_row),
        .rd_data  (bm_rd),
        .wr       (bm_wr),
        .wr_row   (row_reg),
        .free_row (free_row)
    );

    // order links
    spwlo_links #(
        .SLOT_COUNT (SLOT_COUNT),
        .IW         (IW)
    ) u_links (
        .aclk        (aclk),
        .rd_en       (acc),
        .fwd_rd_addr (in_sidx),
        .bwd_rd_addr ((in_op == OP_ALLOC) ? head_reg : in_sidx),
        .fwd_rd_data (fwd_q),
        .bwd_rd_data (bwd_q),
        .fwd_we      (f_we),
        .fwd_wr_addr (f_wa),
        .fwd_wr_data (f_wd),
        .bwd_we      (b_we),
        .bwd_wr_addr (b_wa),
        .bwd_wr_data (b_wd)
    );

    // allocation candidate from the fetched row
    assign alloc_bit  = first_zero(bm_rd);
    assign alloc_x    = (XW'(row_reg) << ROW_BW) | XW'(alloc_bit);
    assign alloc_slot = alloc_x[IW-1:0];
    assign was_used   = range_reg && bm_rd[bit_reg];

    // command sequencer
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        head_next  = head_reg;
        hv_next    = hv_reg;
        a_next     = a_reg;
        tail_next  = tail_reg;
        f_we       = 1'b0;
        f_wa       = a_reg;
        f_wd       = head_reg;
        b_we       = 1'b0;
        b_wa       = a_reg;
        b_wd       = tail_reg;
        bm_wr.en   = 1'b0;
        bm_wr.data = bm_rd;
        out_load   = 1'b0;
        status     = ST_NO_NEXT;
        rslot      = '0;
        inuse      = 1'b0;
        unique case (state_reg)
            FSM_IDLE: begin
                if (acc) begin
                    state_next = FSM_EXEC;
                end
            end
            FSM_EXEC: begin
                out_load   = 1'b1;
                state_next = FSM_IDLE;
                unique case (op_reg)
                    OP_ALLOC: begin
                        if (cnt_reg == CW'(SLOT_COUNT)) begin
                            status = ST_FULL;
                        end else begin
                            status     = ST_OK;
                            rslot      = alloc_slot;
                            cnt_next   = cnt_reg + CW'(1);
                            bm_wr.en   = 1'b1;
                            bm_wr.data = bm_rd | (ROW_W'(1) << alloc_bit);
                            f_we       = 1'b1;
                            f_wa       = alloc_slot;
                            b_we       = 1'b1;
                            b_wa       = alloc_slot;
                            if (!hv_reg) begin
                                // first slot links to itself
                                f_wd      = alloc_slot;
                                b_wd      = alloc_slot;
                                head_next = alloc_slot;
                                hv_next   = 1'b1;
                            end else begin
                                // append behind the tail, neighbors next cycle
                                f_wd       = head_reg;
                                b_wd       = bwd_q;
                                a_next     = alloc_slot;
                                tail_next  = bwd_q;
                                state_next = FSM_LINK;
                            end
                        end
                    end
                    OP_RELEASE: begin
                        if (!was_used) begin
                            status = ST_NOT_USED;
                        end else begin
                            status     = ST_OK;
                            inuse      = 1'b1;
                            cnt_next   = cnt_reg - CW'(1);
                            bm_wr.en   = 1'b1;
                            bm_wr.data = bm_rd & ~(ROW_W'(1) << bit_reg);
                            // unlink: prev -> next, next <- prev
                            f_we       = 1'b1;
                            f_wa       = bwd_q;
                            f_wd       = fwd_q;
                            b_we       = 1'b1;
                            b_wa       = fwd_q;
                            b_wd       = bwd_q;
                            if (cnt_reg == CW'(1)) begin
                                hv_next   = 1'b0;
                                head_next = '0;
                            end else if (head_reg == sidx_reg) begin
                                head_next = fwd_q;
                            end
                        end
                    end
                    OP_NEXT: begin
                        if (was_used) begin
                            inuse = 1'b1;
                            if (fwd_q != head_reg) begin
                                status = ST_OK;
                                rslot  = fwd_q;
                            end
                        end
                    end
                    OP_NONE: begin
                        status = ST_NO_NEXT;
                    end
                    default: begin
                        status = ST_NO_NEXT;
                    end
                endcase
            end
            FSM_LINK: begin
                // old tail points forward to the new slot, head back to it
                f_we       = 1'b1;
                f_wa       = tail_reg;
                f_wd       = a_reg;
                b_we       = 1'b1;
                b_wa       = head_reg;
                b_wd       = a_reg;
                state_next = FSM_IDLE;
            end
            default: begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    // result word
    assign m_tdata_next = {1'b0, hv_next, 6'(head_next), 7'(cnt_next), inuse,
                           6'(rslot), status};

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= FSM_IDLE;
            cnt_reg      <= '0;
            head_reg     <= '0;
            hv_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            head_reg  <= head_next;
            hv_reg    <= hv_next;
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // command and payload registers
    always_ff @(posedge aclk) begin
        a_reg    <= a_next;
        tail_reg <= tail_next;
        if (acc) begin
            op_reg    <= in_op;
            range_reg <= in_range;
            sidx_reg  <= in_sidx;
            row_reg   <= rd_row;
            bit_reg   <= in_x[ROW_BW-1:0];
        end
        if (out_load) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

/* tb/sv/slot_pool_checker.sv */
// ----------------------------------------------------------------------------
// slot_pool_checker: scoreboard for the slot pool with linked order
// Watches the command and result channels, keeps its own copy of the pool
// (used map, forward and backward links, count, head, lowest-free hint),
// predicts one result word per accepted command and compares every field.
// ----------------------------------------------------------------------------
module slot_pool_checker
    import spwlo_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    input  logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,
    input  logic             m_tvalid,
    input  logic             m_tready,
    input  logic [OUT_W-1:0] m_tdata,
    output int               mismatches,
    output int               pending,
    output int               full_replies,
    output int               peak_live
);

    localparam int POOL_SLOTS = 64;
    localparam int REPORT_MAX = 10;

    typedef struct {
        status_t    status;
        logic [5:0] slot;
        logic       in_use;
        logic [6:0] live;
        logic [5:0] head;
        logic       head_valid;
    } pool_reply_t;

    // shadow pool state
    logic       slot_busy [POOL_SLOTS];
    logic [5:0] next_link [POOL_SLOTS];
    logic [5:0] prev_link [POOL_SLOTS];
    logic [6:0] live_total;
    logic [5:0] head_slot;
    logic       head_valid;
    logic [6:0] free_hint;

    pool_reply_t awaited_replies[$];
    pool_reply_t predicted;
    int          replies_seen = 0;

    // lowest free slot at or above start, pool size when none
    function automatic int lowest_free_from(input int start);
        for (int i = start; i < POOL_SLOTS; i++) begin
            if (!slot_busy[i]) begin
                return i;
            end
        end
        return POOL_SLOTS;
    endfunction

    task automatic clear_pool();
        for (int i = 0; i < POOL_SLOTS; i++) begin
            slot_busy[i] = 1'b0;
            next_link[i] = '0;
            prev_link[i] = '0;
        end
        live_total = '0;
        head_slot  = '0;
        head_valid = 1'b0;
        free_hint  = '0;
        awaited_replies.delete();
    endtask

    // apply one command to the shadow pool and build its reply
    task automatic pool_step(input logic [1:0] op_bits, input logic [5:0] idx,
                             output pool_reply_t r);
        int         grant;
        logic [5:0] tail;
        logic [5:0] before_idx;
        logic [5:0] after_idx;
        logic       was_busy;
        was_busy = slot_busy[idx];
        r.status = ST_NO_NEXT;
        r.slot   = '0;
        r.in_use = 1'b0;
        case (op_bits)
            OP_ALLOC: begin
                if (live_total >= POOL_SLOTS) begin
                    r.status = ST_FULL;
                end else begin
                    grant = lowest_free_from(free_hint < POOL_SLOTS ? int'(free_hint) : 0);
                    if (grant >= POOL_SLOTS) begin
                        grant = lowest_free_from(0);
                    end
                    if (grant >= POOL_SLOTS) begin
                        r.status = ST_FULL;
                    end else begin
                        // append at the tail of the circular order
                        if (!head_valid) begin
                            head_slot        = grant[5:0];
                            head_valid       = 1'b1;
                            next_link[grant] = grant[5:0];
                            prev_link[grant] = grant[5:0];
                        end else begin
                            tail                 = prev_link[head_slot];
                            next_link[grant]     = head_slot;
                            prev_link[grant]     = tail;
                            next_link[tail]      = grant[5:0];
                            prev_link[head_slot] = grant[5:0];
                        end
                        slot_busy[grant] = 1'b1;
                        live_total++;
                        free_hint = 7'(lowest_free_from(grant + 1));
                        r.status  = ST_OK;
                        r.slot    = grant[5:0];
                    end
                end
            end
            OP_RELEASE: begin
                if (!was_busy) begin
                    r.status = ST_NOT_USED;
                end else begin
                    before_idx = prev_link[idx];
                    after_idx  = next_link[idx];
                    r.in_use   = 1'b1;
                    live_total--;
                    if (live_total == 0) begin
                        head_valid = 1'b0;
                        head_slot  = '0;
                    end else if (head_slot == idx) begin
                        head_slot = after_idx;
                    end
                    next_link[before_idx] = after_idx;
                    prev_link[after_idx]  = before_idx;
                    slot_busy[idx]        = 1'b0;
                    if (idx < free_hint) begin
                        free_hint = {1'b0, idx};
                    end
                    r.status = ST_OK;
                end
            end
            OP_NEXT: begin
                // successor equal to the head means the walk wrapped
                if (was_busy) begin
                    r.in_use = 1'b1;
                    if (next_link[idx] != head_slot) begin
                        r.status = ST_OK;
                        r.slot   = next_link[idx];
                    end
                end
            end
            default: begin
            end
        endcase
        r.live       = live_total;
        r.head       = head_valid ? head_slot : 6'd0;
        r.head_valid = head_valid;
    endtask

    // compare one result word with the oldest prediction
    task automatic check_reply(input logic [OUT_W-1:0] w);
        pool_reply_t exp_r;
        logic        bad;
        if (awaited_replies.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX) begin
                $display("unexpected result word %h with no command pending", w);
            end
            return;
        end
        exp_r = awaited_replies.pop_front();
        replies_seen++;
        bad = (w[1:0] != exp_r.status) || (w[7:2] != exp_r.slot)
            || (w[8] != exp_r.in_use) || (w[15:9] != exp_r.live)
            || (w[21:16] != exp_r.head) || (w[22] != exp_r.head_valid) || w[23];
        if (bad) begin
            mismatches++;
            if (mismatches <= REPORT_MAX) begin
                $display("result %0d mismatch: expected st=%0d slot=%0d use=%0d live=%0d head=%0d hv=%0d",
                         replies_seen, exp_r.status, exp_r.slot, exp_r.in_use, exp_r.live,
                         exp_r.head, exp_r.head_valid);
                $display("  got st=%0d slot=%0d use=%0d live=%0d head=%0d hv=%0d pad=%0d",
                         w[1:0], w[7:2], w[8], w[15:9], w[21:16], w[22], w[23]);
            end
        end
    endtask

    // results are checked before the new command is predicted
    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_pool();
        end else begin
            if (m_tvalid && m_tready) begin
                check_reply(m_tdata);
            end
            if (s_tvalid && s_tready) begin
                pool_step(s_tdata[1:0], s_tdata[7:2], predicted);
                awaited_replies.push_back(predicted);
                if (predicted.status == ST_FULL) begin
                    full_replies++;
                end
                if (int'(predicted.live) > peak_live) begin
                    peak_live = int'(predicted.live);
                end
            end
        end
        pending = awaited_replies.size();
    end

endmodule

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: testbench for the slot pool with linked order
// Drives directed and random command words through four handshake phases,
// with one long result hold-off, and leaves prediction and comparison to
// the checker beside the block.
// ----------------------------------------------------------------------------
module tb_top
    import spwlo_pkg::*;
();

    localparam int HOLD_CYCLES = 200;
    localparam int IDLE_LIMIT  = 2000;
    localparam int BLOCK_WORDS = 94;

    logic             aclk     = 1'b0;
    logic             aresetn  = 1'b0;
    logic             s_tvalid = 1'b0;
    logic [IN_W-1:0]  s_tdata  = '0;
    logic             m_tready = 1'b0;
    wire              s_tready;
    wire              m_tvalid;
    wire  [OUT_W-1:0] m_tdata;

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int hold_asked   = 0;
    int hold_seen    = 0;
    int hold_left    = 0;
    int idle_cycles  = 0;
    int sent_words   = 0;

    int mismatches;
    int pending;
    int full_replies;
    int peak_live;

    always begin
        aclk = 1'b1;
        #1;
        aclk = 1'b0;
        #1;
    end

    slot_pool_with_linked_order dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    slot_pool_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .mismatches   (mismatches),
        .pending      (pending),
        .full_replies (full_replies),
        .peak_live    (peak_live)
    );

    // result side: random stalls, or a long hold-off when one is asked
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else if (hold_seen != hold_asked) begin
            hold_seen = hold_asked;
            hold_left = HOLD_CYCLES - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles = idle_cycles + 1;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no word moved for %0d cycles, %0d results pending",
                         IDLE_LIMIT, pending);
                $display("tb_top failed");
                $finish;
            end
        end
    end

    // offer one command word, entered and left just after a falling edge
    task automatic send_word(input op_t op, input logic [5:0] idx);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            s_tdata  <= IN_W'($urandom);
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {idx, op};
        do begin
            @(posedge aclk);
        end while (!s_tready);
        sent_words++;
        @(negedge aclk);
    endtask

    // random command with the given allocate and release weights in percent
    task automatic random_command(input int alloc_pct, input int release_pct);
        int         pick;
        op_t        op;
        logic [5:0] idx;
        pick = $urandom_range(99);
        if (pick < alloc_pct) begin
            op = OP_ALLOC;
        end else if (pick < alloc_pct + release_pct) begin
            op = OP_RELEASE;
        end else if (pick < 98) begin
            op = OP_NEXT;
        end else begin
            op = OP_NONE;
        end
        // a quarter of the indexes aim at the low slots, which are busy more often
        if ($urandom_range(3) == 0) begin
            idx = 6'($urandom_range(7));
        end else begin
            idx = 6'($urandom_range(63));
        end
        send_word(op, idx);
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: empty pool, wrap, head and middle release, reuse, drain
        send_word(OP_NEXT, 6'd0);
        send_word(OP_RELEASE, 6'd63);
        send_word(OP_NONE, 6'd0);
        send_word(OP_ALLOC, 6'd0);
        send_word(OP_NEXT, 6'd0);
        send_word(OP_ALLOC, 6'd0);
        send_word(OP_ALLOC, 6'd0);
        send_word(OP_ALLOC, 6'd0);
        send_word(OP_NEXT, 6'd0);
        send_word(OP_NEXT, 6'd3);
        send_word(OP_RELEASE, 6'd0);
        send_word(OP_RELEASE, 6'd2);
        send_word(OP_NEXT, 6'd1);
        send_word(OP_ALLOC, 6'd0);
        send_word(OP_NEXT, 6'd3);
        send_word(OP_RELEASE, 6'd0);
        send_word(OP_NONE, 6'd63);
        send_word(OP_NEXT, 6'd63);
        send_word(OP_RELEASE, 6'd3);
        send_word(OP_RELEASE, 6'd1);
        send_word(OP_RELEASE, 6'd1);
        send_word(OP_ALLOC, 6'd0);

        // random: fill and drain blocks in each handshake phase
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 51; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 51; end
                default: begin tx_idle_pct = 16; rx_stall_pct = 16; end
            endcase
            for (int b = 0; b < 4; b++) begin
                if (p == 0 && b == 1) begin
                    hold_asked++;
                end
                for (int i = 0; i < BLOCK_WORDS; i++) begin
                    if (b % 2 == 0) begin
                        random_command(75, 15);
                    end else begin
                        random_command(15, 65);
                    end
                end
            end
        end
        s_tvalid <= 1'b0;
        rx_stall_pct = 0;

        // drain the outstanding results, then a short tail
        while (pending != 0) begin
            @(posedge aclk);
        end
        repeat (10) @(posedge aclk);

        $display("run covered %0d command words over four handshake phases",
                 sent_words);
        $display("and one long result hold-off; peak live count %0d, %0d pool-full replies",
                 peak_live, full_replies);
        $display("%0d mismatches", mismatches);
        if (mismatches == 0 && pending == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
